FILE: rtl/core/bfs_pkg.sv
package bfs_pkg;

  // Default width of the count and of every factor
  localparam int unsigned COUNT_WIDTH_DEF = 16;

  // Dimension register
  localparam int unsigned DIMS_W = 2;
  localparam logic [DIMS_W-1:0] DIMS_RESET = 2'd2;
  localparam logic [DIMS_W-1:0] DIMS_THREE = 2'd3;

endpackage

FILE: rtl/core/bfs_sdiv.sv
module bfs_sdiv #(
  parameter int unsigned Width = bfs_pkg::COUNT_WIDTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [Width-1:0] dividend_i,
  input  logic [Width-1:0] divisor_i,
  output logic             done_o,
  output logic [Width-1:0] quot_o,
  output logic [Width-1:0] rem_o
);

  localparam int unsigned CntW = $clog2(Width + 1);

  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [Width-1:0] rem_q, rem_d;
  logic [Width-1:0] dvd_q, dvd_d;
  logic [Width-1:0] dvs_q, dvs_d;
  logic [Width:0]   shifted;
  logic [Width:0]   diff;
  logic             ge;
  logic             busy;

  assign busy = (cnt_q != '0);

  // One restoring step: bring in the next dividend bit, subtract if it fits
  assign shifted = {rem_q, dvd_q[Width-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign ge      = ~diff[Width];

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      cnt_d = CntW'(Width);
      rem_d = '0;
      dvd_d = dividend_i;
      dvs_d = divisor_i;
    end else if (busy) begin
      cnt_d = cnt_q - CntW'(1);
      rem_d = ge ? diff[Width-1:0] : shifted[Width-1:0];
      dvd_d = {dvd_q[Width-2:0], ge};
      if (cnt_q == CntW'(1)) begin
        done_d = 1'b1;
      end
    end
  end

  // Hold the step count and the done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  // Shift the partial remainder and quotient
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;
  assign rem_o  = rem_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy)
    else $error("divider started while busy");

  a_start_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> cnt_q == CntW'(Width))
    else $error("divider did not load its step count");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> cnt_q == '0)
    else $error("divider done while still stepping");

  a_rem_small: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && (dvs_q != '0) |-> rem_q < dvs_q)
    else $error("remainder not below divisor");

endmodule

FILE: rtl/core/balanced_factor_split_unit.sv
// Splits a count n into a near-balanced grid by trial division. With dims = 3
// the first factor is the largest divisor r >= 2 of n with r*r*r <= n (else 1),
// and n/r is then split the two-dimensional way into factors b and c; with any
// other dims value the first factor is the largest divisor r >= 2 with r*r <= n
// (else 1), b = n/r and c = 1. One item is worked on at a time. Every candidate
// divisor costs one pass of the bit-serial divider, and the candidates run from
// 2 up to the square or cube root of the number being split; each search ends
// with one more divider pass for the quotient. With the default 16-bit count a
// prime near 65535 in three-dimension mode runs about 295 divider passes. A new
// count is taken while an earlier result still waits on the output. Writes to
// dims apply to the next accepted count.
module balanced_factor_split_unit #(
  parameter int unsigned CountWidth = bfs_pkg::COUNT_WIDTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [bfs_pkg::DIMS_W-1:0] cfg_data_i,
  // input beat
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [CountWidth-1:0]     count_i,
  // output beat
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [CountWidth-1:0]     factor_a_o,
  output logic [CountWidth-1:0]     factor_b_o,
  output logic [CountWidth-1:0]     factor_c_o
);

  localparam int unsigned W  = CountWidth;
  localparam int unsigned PW = CountWidth + 3;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_MOD   = 3'd2;
  localparam logic [2:0] S_QDIV  = 3'd3;
  localparam logic [2:0] S_LOAD  = 3'd4;

  logic [2:0]                 state_q, state_d;
  logic [bfs_pkg::DIMS_W-1:0] dims_q;
  logic                       mode3_q, mode3_d;
  logic                       cube_q, cube_d;
  logic                       phase_q, phase_d;
  logic                       out_valid_q, out_valid_d;

  logic [W-1:0]  x_q, x_d;
  logic [W-1:0]  cand_q, cand_d;
  logic [W-1:0]  best_q, best_d;
  logic [W-1:0]  r1_q, r1_d;
  logic [PW-1:0] sq_q, sq_d;
  logic [PW-1:0] cb_q, cb_d;
  logic [W-1:0]  res_a_q, res_a_d;
  logic [W-1:0]  res_b_q, res_b_d;
  logic [W-1:0]  res_c_q, res_c_d;
  logic [W-1:0]  fa_q, fa_d;
  logic [W-1:0]  fb_q, fb_d;
  logic [W-1:0]  fc_q, fc_d;

  logic [PW-1:0] pw;
  logic          over;
  logic          div_start;
  logic [W-1:0]  div_dvs;
  logic          div_done;
  logic [W-1:0]  div_quot;
  logic [W-1:0]  div_rem;
  logic          out_free;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_free    = !out_valid_q || out_ready_i;

  // Bound test on the current candidate
  assign pw   = cube_q ? cb_q : sq_q;
  assign over = pw > PW'(x_q);

  // Divide by the candidate, or by the best divisor once the bound is passed
  assign div_start = (state_q == S_CHECK);
  assign div_dvs   = over ? best_q : cand_q;

  bfs_sdiv #(
    .Width(W)
  ) u_sdiv (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(x_q),
    .divisor_i (div_dvs),
    .done_o    (div_done),
    .quot_o    (div_quot),
    .rem_o     (div_rem)
  );

  // Sequence the searches and quotient divisions
  always_comb begin
    state_d     = state_q;
    mode3_d     = mode3_q;
    cube_d      = cube_q;
    phase_d     = phase_q;
    out_valid_d = out_valid_q;
    x_d         = x_q;
    cand_d      = cand_q;
    best_d      = best_q;
    r1_d        = r1_q;
    sq_d        = sq_q;
    cb_d        = cb_q;
    res_a_d     = res_a_q;
    res_b_d     = res_b_q;
    res_c_d     = res_c_q;
    fa_d        = fa_q;
    fb_d        = fb_q;
    fc_d        = fc_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          x_d     = count_i;
          mode3_d = (dims_q == bfs_pkg::DIMS_THREE);
          cube_d  = (dims_q == bfs_pkg::DIMS_THREE);
          phase_d = 1'b0;
          cand_d  = W'(2);
          best_d  = W'(1);
          sq_d    = PW'(4);
          cb_d    = PW'(8);
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        state_d = over ? S_QDIV : S_MOD;
      end
      S_MOD: begin
        if (div_done) begin
          if (div_rem == '0) begin
            best_d = cand_q;
          end
          // advance to the next candidate and its square and cube
          cand_d  = cand_q + W'(1);
          sq_d    = sq_q + (PW'(cand_q) << 1) + PW'(1);
          cb_d    = cb_q + (sq_q << 1) + sq_q + (PW'(cand_q) << 1) + PW'(cand_q)
                    + PW'(1);
          state_d = S_CHECK;
        end
      end
      S_QDIV: begin
        if (div_done) begin
          if (phase_q) begin
            res_a_d = r1_q;
            res_b_d = best_q;
            res_c_d = div_quot;
            state_d = S_LOAD;
          end else if (mode3_q) begin
            // split the quotient the two-dimensional way
            r1_d    = best_q;
            x_d     = div_quot;
            phase_d = 1'b1;
            cube_d  = 1'b0;
            cand_d  = W'(2);
            best_d  = W'(1);
            sq_d    = PW'(4);
            cb_d    = PW'(8);
            state_d = S_CHECK;
          end else begin
            res_a_d = best_q;
            res_b_d = div_quot;
            res_c_d = W'(1);
            state_d = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        if (out_free) begin
          fa_d        = res_a_q;
          fb_d        = res_b_q;
          fc_d        = res_c_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold control state and the dims register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      dims_q      <= bfs_pkg::DIMS_RESET;
      mode3_q     <= 1'b0;
      cube_q      <= 1'b0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode3_q     <= mode3_d;
      cube_q      <= cube_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        dims_q <= cfg_data_i;
      end
    end
  end

  // Hold the search and result payload
  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    cand_q  <= cand_d;
    best_q  <= best_d;
    r1_q    <= r1_d;
    sq_q    <= sq_d;
    cb_q    <= cb_d;
    res_a_q <= res_a_d;
    res_b_q <= res_b_d;
    res_c_q <= res_c_d;
    fa_q    <= fa_d;
    fb_q    <= fb_d;
    fc_q    <= fc_d;
  end

  assign out_valid_o = out_valid_q;
  assign factor_a_o  = fa_q;
  assign factor_b_o  = fb_q;
  assign factor_c_o  = fc_q;

  a_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_MOD || state_q == S_QDIV)
    else $error("divider finished outside a wait state");

  a_cand_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CHECK |-> cand_q >= W'(2) && best_q < cand_q)
    else $error("candidate or best divisor out of order");

  a_factor_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> factor_a_o != '0)
    else $error("first factor is zero");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LOAD && out_valid_q && !out_ready_i |=> state_q == S_LOAD)
    else $error("result dropped while output was full");

endmodule

FILE: dv/grid_split_checker.sv
`timescale 1ns / 100ps

module grid_split_checker #(
  parameter int unsigned CountWidth = bfs_pkg::COUNT_WIDTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  input  logic                       cfg_ready_i,
  input  logic [bfs_pkg::DIMS_W-1:0] cfg_data_i,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  logic [CountWidth-1:0]      count_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  logic [CountWidth-1:0]      factor_a_i,
  input  logic [CountWidth-1:0]      factor_b_i,
  input  logic [CountWidth-1:0]      factor_c_i,
  output int unsigned                fail_cnt_o,
  output int unsigned                pend_cnt_o
);

  localparam int unsigned MaxReports = 10;

  typedef struct packed {
    logic [bfs_pkg::DIMS_W-1:0] dims;
    logic [CountWidth-1:0]      count;
    logic [CountWidth-1:0]      a;
    logic [CountWidth-1:0]      b;
    logic [CountWidth-1:0]      c;
  } grid_t;

  grid_t                      want_grids[$];
  logic [bfs_pkg::DIMS_W-1:0] dims_q;
  int unsigned                report_cnt;

  // Largest divisor r >= 2 of n whose square (or cube) stays within n, else 1
  function automatic longint unsigned root_divisor(input longint unsigned n, input bit cube);
    longint unsigned best;
    longint unsigned cand;
    best = 1;
    for (cand = 2; (cube ? cand * cand * cand : cand * cand) <= n; cand++) begin
      if (n % cand == 0) best = cand;
    end
    return best;
  endfunction

  // Work out the grid factors of one count under the given dims setting
  function automatic grid_t predict_grid(input logic [CountWidth-1:0] n,
                                         input logic [bfs_pkg::DIMS_W-1:0] d);
    grid_t           g;
    longint unsigned rest;
    g.dims  = d;
    g.count = n;
    if (d == bfs_pkg::DIMS_THREE) begin
      g.a  = CountWidth'(root_divisor(64'(n), 1'b1));
      rest = 64'(n / g.a);
      g.b  = CountWidth'(root_divisor(rest, 1'b0));
      g.c  = CountWidth'(rest / 64'(g.b));
    end else begin
      g.a = CountWidth'(root_divisor(64'(n), 1'b0));
      g.b = n / g.a;
      g.c = CountWidth'(1);
    end
    return g;
  endfunction

  // Track dims, predict on each count beat, compare on each result beat
  always @(posedge clk_i or negedge rst_ni) begin
    grid_t exp_g;
    if (!rst_ni) begin
      dims_q     <= bfs_pkg::DIMS_RESET;
      fail_cnt_o <= 0;
      pend_cnt_o <= 0;
      report_cnt = 0;
      want_grids.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) dims_q <= cfg_data_i;

      // Check the result beat against the oldest prediction
      if (out_valid_i && out_ready_i) begin
        if (want_grids.size() == 0) begin
          fail_cnt_o <= fail_cnt_o + 1;
          if (report_cnt < MaxReports) begin
            $display("%0t: unexpected result a=%0d b=%0d c=%0d", $realtime,
                     factor_a_i, factor_b_i, factor_c_i);
          end
          report_cnt++;
        end else begin
          exp_g = want_grids.pop_front();
          if (factor_a_i !== exp_g.a || factor_b_i !== exp_g.b || factor_c_i !== exp_g.c) begin
            fail_cnt_o <= fail_cnt_o + 1;
            if (report_cnt < MaxReports) begin
              $display("%0t: count %0d dims %0d: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                       $realtime, exp_g.count, exp_g.dims, exp_g.a, exp_g.b, exp_g.c,
                       factor_a_i, factor_b_i, factor_c_i);
            end
            report_cnt++;
          end
        end
      end

      // Queue the prediction for an accepted count
      if (in_valid_i && in_ready_i) begin
        want_grids.insert(want_grids.size(), predict_grid(count_i, dims_q));
      end

      pend_cnt_o <= want_grids.size();
    end
  end

endmodule

FILE: dv/balanced_factor_split_unit_tb.sv
`timescale 1ns / 100ps

module balanced_factor_split_unit_tb;

  localparam int unsigned CW          = bfs_pkg::COUNT_WIDTH_DEF;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned RAND_ITEMS  = 18;
  localparam int unsigned NUM_PHASES  = 6;

  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       cfg_valid_i = 1'b0;
  logic                       cfg_ready_o;
  logic [bfs_pkg::DIMS_W-1:0] cfg_data_i  = bfs_pkg::DIMS_RESET;
  logic                       in_valid_i  = 1'b0;
  logic                       in_ready_o;
  logic [CW-1:0]              count_i     = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic [CW-1:0]              factor_a_o;
  logic [CW-1:0]              factor_b_o;
  logic [CW-1:0]              factor_c_o;

  int unsigned fail_cnt;
  int unsigned pend_cnt;
  int unsigned cyc_cnt    = 0;
  int unsigned burst_left = 0;
  int unsigned stall_left = 0;
  logic        ready_mode = 1'b0;

  balanced_factor_split_unit #(
    .CountWidth(CW)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .count_i    (count_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .factor_a_o (factor_a_o),
    .factor_b_o (factor_b_o),
    .factor_c_o (factor_c_o)
  );

  grid_split_checker #(
    .CountWidth(CW)
  ) u_grid_chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_i(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_i (in_ready_o),
    .count_i    (count_i),
    .out_valid_i(out_valid_o),
    .out_ready_i(out_ready_i),
    .factor_a_i (factor_a_o),
    .factor_b_i (factor_b_o),
    .factor_c_i (factor_c_o),
    .fail_cnt_o (fail_cnt),
    .pend_cnt_o (pend_cnt)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Stall the result side in runs of ready and not-ready of random length
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      ready_mode = ($urandom_range(0, 2) != 0);
      stall_left = ready_mode ? $urandom_range(1, 60) : $urandom_range(1, 30);
    end
    stall_left--;
    out_ready_i <= ready_mode;
  end

  // Send one count beat, opening a new burst after a random gap when due
  task automatic feed_count(input logic [CW-1:0] v);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      repeat (gap) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    count_i    <= v;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Drain every pending result, then write dims
  task automatic write_dims(input logic [bfs_pkg::DIMS_W-1:0] d);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pend_cnt != 0) @(negedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    logic [bfs_pkg::DIMS_W-1:0] phase_dims [NUM_PHASES];
    int unsigned                dir_counts[$];
    logic [CW-1:0]              v;
    int unsigned                k;

    phase_dims = '{bfs_pkg::DIMS_RESET, bfs_pkg::DIMS_THREE, 2'd0, 2'd1,
                   bfs_pkg::DIMS_THREE, bfs_pkg::DIMS_RESET};

    // Hold reset low, then release it at a falling edge
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int p = 0; p < NUM_PHASES; p++) begin
      // Reset value applies to the first phase
      if (p != 0) write_dims(phase_dims[p]);

      // Directed counts: zero, unit, primes, squares, cubes, full scale
      case (p)
        0: dir_counts = '{0, 1, 2, 3, 4, 65535, 65521, 65025, 32768, 21845};
        1: dir_counts = '{0, 1, 8, 12, 27, 64000, 65535, 65521, 32768};
        2: dir_counts = '{36, 0};
        3: dir_counts = '{65535, 43690};
        default: dir_counts = {};
      endcase
      foreach (dir_counts[i]) feed_count(CW'(dir_counts[i]));

      // Random counts, mostly small or structured so the searches stay short
      for (int i = 0; i < RAND_ITEMS; i++) begin
        case ($urandom_range(0, 9)) inside
          [0:3]: v = CW'($urandom_range(0, 1023));
          [4:5]: v = CW'($urandom());
          [6:7]: v = CW'($urandom_range(2, 255) * $urandom_range(2, 255));
          8: begin
            k = $urandom_range(1, 40);
            v = CW'(k * k * k);
          end
          default: v = CW'(1 << $urandom_range(0, CW - 1));
        endcase
        feed_count(v);
      end
    end

    // Wait out every pending result, then let the block settle
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pend_cnt != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);

    if (fail_cnt == 0 && pend_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
